[src/shortest_queue_dual_fifo_unit_macros.svh]
// Assertion macros for the shortest-queue dual FIFO unit.
// Each macro expands to a labeled concurrent assertion in simulation and
// to nothing under synthesis.
`ifndef SHORTEST_QUEUE_DUAL_FIFO_UNIT_MACROS_SVH
`define SHORTEST_QUEUE_DUAL_FIFO_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// Check a property on every rising edge outside of reset.
`define SQDF_ASSERT(name, clk, rst_n, prop) \
	name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("sqdf assertion failed");

// Check an implication on every rising edge outside of reset.
`define SQDF_ASSERT_IMPL(name, clk, rst_n, cond, prop) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
		else $error("sqdf implication failed");

`else

`define SQDF_ASSERT(name, clk, rst_n, prop)
`define SQDF_ASSERT_IMPL(name, clk, rst_n, cond, prop)

`endif

`endif

[src/sqdf_pkg.sv]
package sqdf_pkg;

	// Total entries shared by both queues
	localparam int CAPACITY = 16;
	localparam int PTR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int SUM_W = CNT_W + 1;

	// Fixed field widths of the stream words
	localparam int ACTION_W = 2;
	localparam int VALUE_W = 32;
	localparam int COUNT_FIELD_W = 5;
	localparam int IN_DATA_W = 32;
	localparam int OUT_DATA_W = 80;

	// Operation carried in the input tuser
	typedef enum logic [ACTION_W-1:0] {
		ACT_QUERY = 2'd0,
		ACT_ENQ = 2'd1,
		ACT_DEQ_FIRST = 2'd2,
		ACT_DEQ_SECOND = 2'd3
	} action_t;

	typedef logic [PTR_W-1:0] ptr_t;
	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic [VALUE_W-1:0] value_t;

	// Advance a ring pointer with wrap at CAPACITY
	function automatic ptr_t ptr_next(input ptr_t p);
		logic [PTR_W:0] inc;
		inc = {1'b0, p} + (PTR_W + 1)'(1);
		return (inc == (PTR_W + 1)'(CAPACITY)) ? '0 : inc[PTR_W-1:0];
	endfunction

endpackage

[src/shortest_queue_dual_fifo_unit.sv]
// Channel  | Dir | tdata                                   | tuser    | tlast
// s_*      | in  | [31:0] value                            | [1:0] op | -
// m_*      | out | ok, went_to_second, counts, heads (80b) | -        | -
//
// One word is accepted per cycle while s_tready is high; each result passes
// through stage one and the output register. Each word does at most one
// write to one ring memory and one read of each; stage one holds the reads.
// Reset clears pointers, counts and valids; memory contents stay undefined.
// A stall on m_* holds the result and the stage behind it; s_tready drops only
// when both are full.
`include "shortest_queue_dual_fifo_unit_macros.svh"

module shortest_queue_dual_fifo_unit import sqdf_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,  // [31:0] value
	input  logic [ACTION_W-1:0]   s_tuser,  // [1:0] action
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata   // [0] ok, [1] went_to_second,
	                                        // [6:2] first_count, [11:7] second_count,
	                                        // [12] first_head_valid, [44:13] first_head,
	                                        // [45] second_head_valid, [77:46] second_head,
	                                        // [79:78] zero
);

	// Ring memories
	value_t first_mem [CAPACITY];
	value_t second_mem [CAPACITY];

	// Queue state
	ptr_t first_rd_q, first_wr_q, second_rd_q, second_wr_q;
	cnt_t first_cnt_q, second_cnt_q;

	// Stage one: memory read in flight
	logic s1_q;
	logic ok_s1, to_second_s1;
	cnt_t first_cnt_s1, second_cnt_s1;
	logic first_fwd_s1, second_fwd_s1;
	value_t fwd_value_s1;
	value_t first_rdata_s1, second_rdata_s1;

	// Output register
	logic out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;

	// Handshake
	logic out_free, load_out, accept;
	action_t act;
	value_t value;

	// Next state
	logic ok_d, to_second_d;
	logic first_we, second_we;
	ptr_t first_rd_d, first_wr_d, second_rd_d, second_wr_d;
	cnt_t first_cnt_d, second_cnt_d;
	logic [SUM_W-1:0] total;

	// Result assembly
	logic first_hv, second_hv;
	value_t first_head, second_head;

	assign out_free = !out_valid_q || m_tready;
	assign load_out = s1_q && out_free;
	assign s_tready = !s1_q || out_free;
	assign accept = s_tvalid && s_tready;
	assign act = action_t'(s_tuser);
	assign value = s_tdata[VALUE_W-1:0];
	assign total = SUM_W'(first_cnt_q) + SUM_W'(second_cnt_q);

	// Decode the operation and pick the target queue
	always_comb begin
		ok_d = 1'b1;
		to_second_d = 1'b0;
		first_we = 1'b0;
		second_we = 1'b0;
		first_rd_d = first_rd_q;
		first_wr_d = first_wr_q;
		second_rd_d = second_rd_q;
		second_wr_d = second_wr_q;
		first_cnt_d = first_cnt_q;
		second_cnt_d = second_cnt_q;
		unique case (act)
			ACT_QUERY: begin
			end
			ACT_ENQ: begin
				if (total >= SUM_W'(CAPACITY)) begin
					ok_d = 1'b0;
				end else if (first_cnt_q <= second_cnt_q) begin
					first_we = 1'b1;
					first_wr_d = ptr_next(first_wr_q);
					first_cnt_d = first_cnt_q + CNT_W'(1);
				end else begin
					second_we = 1'b1;
					second_wr_d = ptr_next(second_wr_q);
					second_cnt_d = second_cnt_q + CNT_W'(1);
					to_second_d = 1'b1;
				end
			end
			ACT_DEQ_FIRST: begin
				if (first_cnt_q == '0) begin
					ok_d = 1'b0;
				end else begin
					first_rd_d = ptr_next(first_rd_q);
					first_cnt_d = first_cnt_q - CNT_W'(1);
				end
			end
			ACT_DEQ_SECOND: begin
				if (second_cnt_q == '0) begin
					ok_d = 1'b0;
				end else begin
					second_rd_d = ptr_next(second_rd_q);
					second_cnt_d = second_cnt_q - CNT_W'(1);
				end
			end
		endcase
	end

	// Write the enqueued word and read both new heads
	always_ff @(posedge clk) begin
		if (accept) begin
			if (first_we) begin
				first_mem[first_wr_q] <= value;
			end
			if (second_we) begin
				second_mem[second_wr_q] <= value;
			end
			first_rdata_s1 <= first_mem[first_rd_d];
			second_rdata_s1 <= second_mem[second_rd_d];
		end
	end

	// Update queue state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_rd_q <= '0;
			first_wr_q <= '0;
			second_rd_q <= '0;
			second_wr_q <= '0;
			first_cnt_q <= '0;
			second_cnt_q <= '0;
		end else if (accept) begin
			first_rd_q <= first_rd_d;
			first_wr_q <= first_wr_d;
			second_rd_q <= second_rd_d;
			second_wr_q <= second_wr_d;
			first_cnt_q <= first_cnt_d;
			second_cnt_q <= second_cnt_d;
		end
	end

	// Advance stage one valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_q <= 1'b0;
		end else if (accept) begin
			s1_q <= 1'b1;
		end else if (load_out) begin
			s1_q <= 1'b0;
		end
	end

	// Capture stage one payload; forward a word written into an empty queue
	always_ff @(posedge clk) begin
		if (accept) begin
			ok_s1 <= ok_d;
			to_second_s1 <= to_second_d;
			first_cnt_s1 <= first_cnt_d;
			second_cnt_s1 <= second_cnt_d;
			first_fwd_s1 <= first_we && (first_cnt_q == '0);
			second_fwd_s1 <= second_we && (second_cnt_q == '0);
			fwd_value_s1 <= value;
		end
	end

	// Select heads, zero when the queue is empty
	always_comb begin
		first_hv = (first_cnt_s1 != '0);
		second_hv = (second_cnt_s1 != '0);
		first_head = '0;
		second_head = '0;
		if (first_hv) begin
			first_head = first_fwd_s1 ? fwd_value_s1 : first_rdata_s1;
		end
		if (second_hv) begin
			second_head = second_fwd_s1 ? fwd_value_s1 : second_rdata_s1;
		end
	end

	// Hold the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_data_q <= {2'b00, second_head, second_hv, first_head, first_hv,
				COUNT_FIELD_W'(second_cnt_s1), COUNT_FIELD_W'(first_cnt_s1),
				to_second_s1, ok_s1};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = out_data_q;

	// Checks
	`SQDF_ASSERT(a_total_within_capacity, clk, arst_n,
		(SUM_W'(first_cnt_q) + SUM_W'(second_cnt_q) <= SUM_W'(CAPACITY)))
	`SQDF_ASSERT(a_first_ptrs_match_count, clk, arst_n,
		((SUM_W'(first_rd_q) + SUM_W'(first_cnt_q) == SUM_W'(first_wr_q)) ||
		(SUM_W'(first_rd_q) + SUM_W'(first_cnt_q) == SUM_W'(first_wr_q) + SUM_W'(CAPACITY))))
	`SQDF_ASSERT(a_second_ptrs_match_count, clk, arst_n,
		((SUM_W'(second_rd_q) + SUM_W'(second_cnt_q) == SUM_W'(second_wr_q)) ||
		(SUM_W'(second_rd_q) + SUM_W'(second_cnt_q) == SUM_W'(second_wr_q) + SUM_W'(CAPACITY))))
	`SQDF_ASSERT_IMPL(a_stage_drains, clk, arst_n, s1_q && !out_valid_q, ##1 out_valid_q)

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
	import sqdf_pkg::*;

	localparam int CLK_HALF = 5;
	localparam int RESET_CYCLES = 12;
	localparam int PHASE_WORDS = 375;
	localparam int DRAIN_CYCLES = 20;
	localparam int CYCLE_LIMIT = 500000;
	localparam int MAX_REPORTS = 40;

	// Result word, laid out from bit 79 down to bit 0 as on m_tdata
	typedef struct packed {
		logic [1:0]  pad;
		logic [31:0] second_head;
		logic        second_head_valid;
		logic [31:0] first_head;
		logic        first_head_valid;
		logic [4:0]  second_count;
		logic [4:0]  first_count;
		logic        went_to_second;
		logic        ok;
	} status_word_t;

	typedef struct {
		action_t      act;
		value_t       val;
		bit           typed;
		status_word_t status;
	} directed_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic [ACTION_W-1:0]   s_tuser = ACT_QUERY;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;

	// Shadow copy of both sub-queues and the results still owed
	value_t        shadow_first[$];
	value_t        shadow_second[$];
	status_word_t  pending_status[$];
	directed_row_t directed_rows[$];

	int src_idle_pct = 0;
	int sink_stall_pct = 0;
	int err_count = 0;
	int cycle_count = 0;
	int words_sent = 0;
	int words_checked = 0;
	int full_refusals = 0;
	int empty_refusals = 0;
	int to_second_count = 0;

	shortest_queue_dual_fifo_unit u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #CLK_HALF clk = ~clk;

	// Build a status word; heads read as zero when their queue is empty
	function automatic status_word_t make_status(input logic ok, input logic to_second,
			input int first_n, input int second_n, input value_t first_v,
			input value_t second_v);
		status_word_t w;
		w = '0;
		w.ok = ok;
		w.went_to_second = to_second;
		w.first_count = first_n[4:0];
		w.second_count = second_n[4:0];
		w.first_head_valid = (first_n != 0);
		w.first_head = (first_n != 0) ? first_v : '0;
		w.second_head_valid = (second_n != 0);
		w.second_head = (second_n != 0) ? second_v : '0;
		return w;
	endfunction

	// Apply one operation to the shadow queues and return the status after it
	function automatic status_word_t predict_status(input action_t act, input value_t val);
		logic ok;
		logic to_second;
		ok = 1'b1;
		to_second = 1'b0;
		case (act)
			ACT_ENQ: begin
				if (shadow_first.size() + shadow_second.size() >= CAPACITY) begin
					ok = 1'b0;
				end else if (shadow_first.size() <= shadow_second.size()) begin
					shadow_first.push_back(val);
				end else begin
					shadow_second.push_back(val);
					to_second = 1'b1;
				end
			end
			ACT_DEQ_FIRST: begin
				if (shadow_first.size() == 0) ok = 1'b0;
				else void'(shadow_first.pop_front());
			end
			ACT_DEQ_SECOND: begin
				if (shadow_second.size() == 0) ok = 1'b0;
				else void'(shadow_second.pop_front());
			end
			default: ;
		endcase
		return make_status(ok, to_second, shadow_first.size(), shadow_second.size(),
			(shadow_first.size() != 0) ? shadow_first[0] : '0,
			(shadow_second.size() != 0) ? shadow_second[0] : '0);
	endfunction

	task automatic add_row(input action_t act, input value_t val, input bit typed,
			input status_word_t status);
		directed_row_t row;
		row.act = act;
		row.val = val;
		row.typed = typed;
		row.status = status;
		directed_rows.push_back(row);
	endtask

	// Drive one word from a falling edge, hold it until accepted, then queue its status
	task automatic send_word(input action_t act, input value_t val, input bit typed,
			input status_word_t typed_status);
		status_word_t predicted;
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= val;
		s_tuser <= act;
		forever begin
			@(posedge clk);
			if (s_tready) break;
		end
		predicted = predict_status(act, val);
		pending_status.push_back(typed ? typed_status : predicted);
		words_sent++;
		if (!predicted.ok && act == ACT_ENQ) full_refusals++;
		if (!predicted.ok && act != ACT_ENQ) empty_refusals++;
		if (predicted.went_to_second) to_second_count++;
		@(negedge clk);
	endtask

	task automatic wait_all_results();
		s_tvalid <= 1'b0;
		while (pending_status.size() != 0) @(negedge clk);
	endtask

	task automatic compare_field(input string name, input logic [31:0] exp_v,
			input logic [31:0] act_v);
		if (exp_v !== act_v) begin
			err_count++;
			if (err_count <= MAX_REPORTS)
				$display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, act_v);
		end
	endtask

	// Receiver: random stall, updated on the falling edge
	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= sink_stall_pct);
	end

	// Check each result word against the oldest pending status
	always @(posedge clk) begin
		status_word_t got;
		status_word_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata;
			if (pending_status.size() == 0) begin
				err_count++;
				if (err_count <= MAX_REPORTS)
					$display("%0t: unexpected result word, expected none, got %h",
						$time, m_tdata);
			end else begin
				want = pending_status.pop_front();
				words_checked++;
				compare_field("ok", 32'(want.ok), 32'(got.ok));
				compare_field("went_to_second", 32'(want.went_to_second),
					32'(got.went_to_second));
				compare_field("first_count", 32'(want.first_count), 32'(got.first_count));
				compare_field("second_count", 32'(want.second_count),
					32'(got.second_count));
				compare_field("first_head_valid", 32'(want.first_head_valid),
					32'(got.first_head_valid));
				compare_field("first_head", want.first_head, got.first_head);
				compare_field("second_head_valid", 32'(want.second_head_valid),
					32'(got.second_head_valid));
				compare_field("second_head", want.second_head, got.second_head);
				compare_field("pad", 32'(want.pad), 32'(got.pad));
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d results pending",
				cycle_count, pending_status.size());
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		value_t val;
		action_t act;
		int r;
		int run_left;
		bit filling;
		int idle_src [4];
		int idle_sink [4];

		idle_src = '{0, 85, 0, 31};
		idle_sink = '{0, 0, 85, 31};

		// Directed rows: empty block, both extremes, tie and full refusal
		add_row(ACT_QUERY, 32'h0, 1'b1, make_status(1'b1, 1'b0, 0, 0, 0, 0));
		add_row(ACT_DEQ_FIRST, 32'h0, 1'b1, make_status(1'b0, 1'b0, 0, 0, 0, 0));
		add_row(ACT_DEQ_SECOND, 32'hFFFF_FFFF, 1'b1, make_status(1'b0, 1'b0, 0, 0, 0, 0));
		add_row(ACT_ENQ, 32'h8000_0000, 1'b1,
			make_status(1'b1, 1'b0, 1, 0, 32'h8000_0000, 0));
		add_row(ACT_ENQ, 32'h7FFF_FFFF, 1'b1,
			make_status(1'b1, 1'b1, 1, 1, 32'h8000_0000, 32'h7FFF_FFFF));
		add_row(ACT_QUERY, 32'h1234_5678, 1'b1,
			make_status(1'b1, 1'b0, 1, 1, 32'h8000_0000, 32'h7FFF_FFFF));
		for (int i = 0; i < 14; i++) begin
			val = (i == 0) ? 32'hFFFF_FFFF : (i == 1) ? 32'h0 : (i == 2) ? 32'hAAAA_AAAA :
				(i == 3) ? 32'h5555_5555 : $urandom;
			add_row(ACT_ENQ, val, 1'b0, '0);
		end
		add_row(ACT_ENQ, 32'hDEAD_BEEF, 1'b1,
			make_status(1'b0, 1'b0, 8, 8, 32'h8000_0000, 32'h7FFF_FFFF));
		add_row(ACT_DEQ_FIRST, 32'h0, 1'b0, '0);
		add_row(ACT_DEQ_SECOND, 32'h0, 1'b0, '0);
		add_row(ACT_ENQ, 32'h0000_0001, 1'b0, '0);
		add_row(ACT_QUERY, 32'h0, 1'b0, '0);

		// Reset once, release on a falling edge
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_rows[i])
			send_word(directed_rows[i].act, directed_rows[i].val, directed_rows[i].typed,
				directed_rows[i].status);
		wait_all_results();

		// Random phases: alternate filling and draining runs to hit full, empty and wrap
		for (int ph = 0; ph < 4; ph++) begin
			src_idle_pct = idle_src[ph];
			sink_stall_pct = idle_sink[ph];
			filling = 1'b1;
			run_left = $urandom_range(60, 10);
			for (int n = 0; n < PHASE_WORDS; n++) begin
				if (run_left == 0) begin
					filling = !filling;
					run_left = $urandom_range(60, 10);
				end
				run_left--;
				r = $urandom_range(99);
				if (r < 8) act = ACT_QUERY;
				else if (r < (filling ? 70 : 30)) act = ACT_ENQ;
				else if (r < (filling ? 85 : 65)) act = ACT_DEQ_FIRST;
				else act = ACT_DEQ_SECOND;
				case ($urandom_range(11))
					0: val = 32'h8000_0000;
					1: val = 32'h7FFF_FFFF;
					2: val = 32'h0;
					default: val = $urandom;
				endcase
				send_word(act, val, 1'b0, '0);
			end
			// Hold off the sender until the block has returned everything
			wait_all_results();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d words, checked %0d results under four handshake phases.",
			words_sent, words_checked);
		$display("Refused: %0d enqueues on full, %0d dequeues on empty; %0d to queue two.",
			full_refusals, empty_refusals, to_second_count);
		if (err_count == 0 && pending_status.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

[shortest_queue_dual_fifo_unit.f]
+incdir+src
src/sqdf_pkg.sv
src/shortest_queue_dual_fifo_unit.sv
tb/sv/tb_top.sv
